>>> src/fxatan_pkg.sv
// ----------------------------------------------------------------------------
// fxatan_pkg
// Shared types and constants for the q32.32 atan2 pipeline.
// ----------------------------------------------------------------------------
package fxatan_pkg;

  localparam int FRAC_BITS    = 32;
  localparam int DIV_STEPS    = 32;
  localparam int HORNER_STEPS = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int ANGLE_W      = 35;

  localparam logic [ANGLE_W-1:0] Q_PI      = 35'h3243F6A88;
  localparam logic [ANGLE_W-1:0] Q_HALF_PI = 35'h1921FB544;
  localparam logic [ANGLE_W-1:0] Q_QUART_PI = 35'h0C90FDAA2;

  // polynomial coefficients, sign extended to 35 bits
  localparam logic signed [ANGLE_W-1:0] K0 = 35'sh0FFF737DA;
  localparam logic signed [ANGLE_W-1:0] K1 = 35'sh7AB717DF2;
  localparam logic signed [ANGLE_W-1:0] K2 = 35'sh02E1DB877;
  localparam logic signed [ANGLE_W-1:0] K3 = 35'sh7EA34B946;
  localparam logic signed [ANGLE_W-1:0] K4 = 35'sh0055572F9;

  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } side_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    side_t       side;
  } work_t;

  // coefficient added after Horner step idx
  function automatic logic signed [ANGLE_W-1:0] horner_coef(input logic [1:0] idx);
    logic signed [ANGLE_W-1:0] c;
    case (idx)
      2'd0:    c = K3;
      2'd1:    c = K2;
      2'd2:    c = K1;
      default: c = K0;
    endcase
    return c;
  endfunction

endpackage

>>> src/fxatan_front.sv
// ----------------------------------------------------------------------------
// fxatan_front
// Input stage: magnitudes, octant swap and special-case flags.
// ----------------------------------------------------------------------------
module fxatan_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [63:0]  in_y_value,
  input  logic signed [63:0]  in_x_value,
  output logic                wk_valid,
  input  logic                wk_ready,
  output fxatan_pkg::work_t   wk_work
);

  logic              fv_r, fv_nxt;
  fxatan_pkg::work_t fw_r, fw_nxt;
  logic [63:0]       ay, ax;
  logic              take;

  assign in_ready = !fv_r || wk_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    ay = in_y_value[63] ? (64'd0 - in_y_value) : in_y_value;
    ax = in_x_value[63] ? (64'd0 - in_x_value) : in_x_value;
    fw_nxt.side.zero = (in_y_value == 64'sd0) && (in_x_value == 64'sd0);
    fw_nxt.side.swap = ay > ax;
    fw_nxt.side.xneg = in_x_value[63];
    fw_nxt.side.yneg = in_y_value[63];
    fw_nxt.num       = (ay > ax) ? ax : ay;
    fw_nxt.den       = (ay > ax) ? ay : ax;
    fv_nxt = take ? 1'b1 : (wk_ready ? 1'b0 : fv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fw_r <= fw_nxt;
    end
  end

  assign wk_valid = fv_r;
  assign wk_work  = fw_r;

endmodule

>>> src/fxatan_queue.sv
// ----------------------------------------------------------------------------
// fxatan_queue
// Small FIFO between the front stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module fxatan_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  fxatan_pkg::work_t push_work,
  output logic              pop_valid,
  input  logic              pop_ready,
  output fxatan_pkg::work_t pop_work
);

  localparam int D  = fxatan_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  fxatan_pkg::work_t mem_r [D];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_ready = cnt_r != (AW+1)'(D);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_work   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_work;
    end
  end

endmodule

>>> src/fxatan_back.sv
// ----------------------------------------------------------------------------
// fxatan_back
// Arithmetic pipeline: two restoring dividers, Horner polynomial, quadrant fix.
// ----------------------------------------------------------------------------
module fxatan_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hd_valid,
  output logic              hd_ready,
  input  fxatan_pkg::work_t hd_work,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [34:0]       out_angle
);

  localparam int N  = fxatan_pkg::DIV_STEPS;
  localparam int HS = fxatan_pkg::HORNER_STEPS;
  localparam int AW = fxatan_pkg::ANGLE_W;

  typedef struct packed {
    fxatan_pkg::side_t side;
    logic              red;
    logic [31:0]       z;
    logic [30:0]       z2;
  } carry_t;

  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign hd_ready = adv;

  // ---------------- divider 1: min / max ----------------
  logic [N:0]        d1_v_r;
  logic [63:0]       d1_rem_r [0:N];
  logic [63:0]       d1_den_r [0:N];
  logic [31:0]       d1_quo_r [0:N];
  logic              d1_one_r [0:N];
  fxatan_pkg::side_t d1_sd_r  [0:N];
  logic [63:0]       d1_sh    [0:N-1];
  logic              d1_ge    [0:N-1];
  logic [63:0]       d1_rem_nxt [0:N-1];
  logic [31:0]       d1_quo_nxt [0:N-1];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      d1_sh[k]      = {d1_rem_r[k][62:0], 1'b0};
      d1_ge[k]      = d1_sh[k] >= d1_den_r[k];
      d1_rem_nxt[k] = d1_ge[k] ? (d1_sh[k] - d1_den_r[k]) : d1_sh[k];
      d1_quo_nxt[k] = {d1_quo_r[k][30:0], d1_ge[k]};
    end
  end

  // ---------------- range reduction ----------------
  logic [32:0] z1;
  logic        red_c;
  logic [32:0] rn;
  logic [33:0] rd;

  always_comb begin
    z1    = d1_one_r[N] ? 33'h1_0000_0000 : {1'b0, d1_quo_r[N]};
    red_c = z1 > 33'h0_8000_0000;
    rn    = 33'h1_0000_0000 - z1;
    rd    = {1'b0, z1} + 34'h1_0000_0000;
  end

  // ---------------- divider 2: (1-z)/(1+z) ----------------
  logic [N:0]        d2_v_r;
  logic [33:0]       d2_rem_r [0:N];
  logic [33:0]       d2_den_r [0:N];
  logic [31:0]       d2_quo_r [0:N];
  logic              d2_red_r [0:N];
  logic [31:0]       d2_zp_r  [0:N];
  fxatan_pkg::side_t d2_sd_r  [0:N];
  logic [33:0]       d2_sh    [0:N-1];
  logic              d2_ge    [0:N-1];
  logic [33:0]       d2_rem_nxt [0:N-1];
  logic [31:0]       d2_quo_nxt [0:N-1];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      d2_sh[k]      = {d2_rem_r[k][32:0], 1'b0};
      d2_ge[k]      = d2_sh[k] >= d2_den_r[k];
      d2_rem_nxt[k] = d2_ge[k] ? (d2_sh[k] - d2_den_r[k]) : d2_sh[k];
      d2_quo_nxt[k] = {d2_quo_r[k][30:0], d2_ge[k]};
    end
  end

  // ---------------- square ----------------
  logic        sq_v_r;
  carry_t      sq_c_r, sq_c_nxt;
  logic [31:0] sq_z;
  logic [63:0] sq_prod;

  always_comb begin
    sq_z          = d2_red_r[N] ? d2_quo_r[N] : d2_zp_r[N];
    sq_prod       = 64'(sq_z) * 64'(sq_z);
    sq_c_nxt.side = d2_sd_r[N];
    sq_c_nxt.red  = d2_red_r[N];
    sq_c_nxt.z    = sq_z;
    sq_c_nxt.z2   = sq_prod[62:32];
  end

  // ---------------- Horner: multiply then add, per step ----------------
  logic [HS-1:0]          hm_v_r, ha_v_r;
  logic [32:0]            hm_m_r   [0:HS-1];
  logic                   hm_neg_r [0:HS-1];
  carry_t                 hm_c_r   [0:HS-1];
  logic signed [AW-1:0]   ha_p_r   [0:HS-1];
  carry_t                 ha_c_r   [0:HS-1];
  logic signed [AW-1:0]   hm_p_in  [0:HS-1];
  carry_t                 hm_c_in  [0:HS-1];
  logic [AW-1:0]          hm_abs   [0:HS-1];
  logic [64:0]            hm_prod  [0:HS-1];
  logic [AW-1:0]          ha_t     [0:HS-1];
  logic signed [AW-1:0]   ha_p_nxt [0:HS-1];

  always_comb begin
    hm_p_in[0] = fxatan_pkg::K4;
    hm_c_in[0] = sq_c_r;
    for (int i = 1; i < HS; i++) begin
      hm_p_in[i] = ha_p_r[i-1];
      hm_c_in[i] = ha_c_r[i-1];
    end
    for (int i = 0; i < HS; i++) begin
      hm_abs[i]   = hm_p_in[i][AW-1] ? AW'(-hm_p_in[i]) : AW'(hm_p_in[i]);
      hm_prod[i]  = 65'(hm_abs[i][33:0]) * 65'(hm_c_in[i].z2);
      ha_t[i]     = hm_neg_r[i] ? (AW'(0) - {2'b0, hm_m_r[i]}) : {2'b0, hm_m_r[i]};
      ha_p_nxt[i] = $signed(ha_t[i]) + fxatan_pkg::horner_coef(2'(i));
    end
  end

  // ---------------- z * p ----------------
  logic        fm_v_r;
  logic [33:0] fm_m_r;
  logic        fm_neg_r;
  carry_t      fm_c_r;
  logic [AW-1:0] fm_abs;
  logic [65:0]   fm_prod;

  always_comb begin
    fm_abs  = ha_p_r[HS-1][AW-1] ? AW'(-ha_p_r[HS-1]) : AW'(ha_p_r[HS-1]);
    fm_prod = 66'(fm_abs[33:0]) * 66'(ha_c_r[HS-1].z);
  end

  // ---------------- reduction undo ----------------
  logic              cb_v_r;
  logic [AW-1:0]     cb_res_r, cb_res_nxt;
  fxatan_pkg::side_t cb_sd_r;
  logic [AW-1:0]     cb_t, cb_sum;

  always_comb begin
    cb_t       = fm_neg_r ? (AW'(0) - {1'b0, fm_m_r}) : {1'b0, fm_m_r};
    cb_sum     = (fm_c_r.red ? fxatan_pkg::Q_QUART_PI : AW'(0)) + cb_t;
    cb_res_nxt = fm_c_r.red ? (fxatan_pkg::Q_HALF_PI - cb_sum) : cb_sum;
  end

  // ---------------- octant and quadrant ----------------
  logic [AW-1:0] out_angle_r, out_angle_nxt;
  logic [AW-1:0] qa1, qa2, qa3;

  always_comb begin
    qa1 = cb_sd_r.swap ? (fxatan_pkg::Q_HALF_PI - cb_res_r) : cb_res_r;
    qa2 = cb_sd_r.xneg ? (fxatan_pkg::Q_PI - qa1) : qa1;
    qa3 = cb_sd_r.yneg ? (AW'(0) - qa2) : qa2;
    out_angle_nxt = cb_sd_r.zero ? AW'(0) : qa3;
  end

  // ---------------- valid pipeline ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r      <= '0;
      d2_v_r      <= '0;
      sq_v_r      <= 1'b0;
      hm_v_r      <= '0;
      ha_v_r      <= '0;
      fm_v_r      <= 1'b0;
      cb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      d1_v_r      <= {d1_v_r[N-1:0], hd_valid};
      d2_v_r      <= {d2_v_r[N-1:0], d1_v_r[N]};
      sq_v_r      <= d2_v_r[N];
      hm_v_r      <= {ha_v_r[HS-2:0], sq_v_r};
      ha_v_r      <= hm_v_r;
      fm_v_r      <= ha_v_r[HS-1];
      cb_v_r      <= fm_v_r;
      out_valid_r <= cb_v_r;
    end
  end

  // ---------------- payload pipeline ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_rem_r[0] <= hd_work.num;
      d1_den_r[0] <= hd_work.den;
      d1_quo_r[0] <= '0;
      d1_one_r[0] <= hd_work.num >= hd_work.den;
      d1_sd_r[0]  <= hd_work.side;
      for (int k = 0; k < N; k++) begin
        d1_rem_r[k+1] <= d1_rem_nxt[k];
        d1_den_r[k+1] <= d1_den_r[k];
        d1_quo_r[k+1] <= d1_quo_nxt[k];
        d1_one_r[k+1] <= d1_one_r[k];
        d1_sd_r[k+1]  <= d1_sd_r[k];
      end

      d2_rem_r[0] <= {1'b0, rn};
      d2_den_r[0] <= rd;
      d2_quo_r[0] <= '0;
      d2_red_r[0] <= red_c;
      d2_zp_r[0]  <= z1[31:0];
      d2_sd_r[0]  <= d1_sd_r[N];
      for (int k = 0; k < N; k++) begin
        d2_rem_r[k+1] <= d2_rem_nxt[k];
        d2_den_r[k+1] <= d2_den_r[k];
        d2_quo_r[k+1] <= d2_quo_nxt[k];
        d2_red_r[k+1] <= d2_red_r[k];
        d2_zp_r[k+1]  <= d2_zp_r[k];
        d2_sd_r[k+1]  <= d2_sd_r[k];
      end

      sq_c_r <= sq_c_nxt;

      for (int i = 0; i < HS; i++) begin
        hm_m_r[i]   <= hm_prod[i][64:32];
        hm_neg_r[i] <= hm_p_in[i][AW-1];
        hm_c_r[i]   <= hm_c_in[i];
        ha_p_r[i]   <= ha_p_nxt[i];
        ha_c_r[i]   <= hm_c_r[i];
      end

      fm_m_r   <= fm_prod[65:32];
      fm_neg_r <= ha_p_r[HS-1][AW-1];
      fm_c_r   <= ha_c_r[HS-1];

      cb_res_r <= cb_res_nxt;
      cb_sd_r  <= fm_c_r.side;

      out_angle_r <= out_angle_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

>>> src/fixed_point_atan2_top.sv
// ----------------------------------------------------------------------------
// fixed_point_atan2_top
// Streaming atan2(y, x) on signed q32.32 operands, result in signed q3.32 radians.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+----------------
//  input   | in_y_value[63:0], in_x_value[63:0]      | in  | in_valid/in_ready
//  result  | out_angle[34:0]                         | out | out_valid/out_ready
//
//  Throughput is one beat per cycle while the result side does not stall; a beat
//  passes the front and queue registers, the two 33-stage restoring dividers
//  (a load stage plus one quotient bit per stage), then the square, the
//  eight-stage Horner chain and three output stages on its way to out_valid.
//  rst_n (synchronous, active low) clears all valid flags; data regs are not reset.
//  A stalled result freezes the arithmetic pipeline only; the front stage and
//  the 4-entry queue keep taking input beats until the queue fills.
//
module fixed_point_atan2_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_y_value,
  input  logic signed [63:0] in_x_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [34:0] out_angle
);

  // front -> queue
  logic              wk_valid, wk_ready;
  fxatan_pkg::work_t wk_work;
  // queue -> back
  logic              hd_valid, hd_ready;
  fxatan_pkg::work_t hd_work;
  logic [34:0]       angle_w;

  // magnitudes, octant swap, zero detect
  fxatan_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_y_value (in_y_value),
    .in_x_value (in_x_value),
    .wk_valid   (wk_valid),
    .wk_ready   (wk_ready),
    .wk_work    (wk_work)
  );

  // decouples the front from back-pressure on the result side
  fxatan_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (wk_valid),
    .push_ready (wk_ready),
    .push_work  (wk_work),
    .pop_valid  (hd_valid),
    .pop_ready  (hd_ready),
    .pop_work   (hd_work)
  );

  // divide, reduce, polynomial, quadrant correction
  fxatan_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hd_valid  (hd_valid),
    .hd_ready  (hd_ready),
    .hd_work   (hd_work),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_angle (angle_w)
  );

  assign out_angle = $signed(angle_w);

`ifndef SYNTHESIS
  // a full queue stays full until the pipeline pops it
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!wk_ready && !(hd_valid && hd_ready)) |=> !wk_ready)
    else $error("queue drained without a pop");

  // a new result only appears after the pipeline advanced
  a_out_after_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(hd_ready))
    else $error("result appeared while pipeline was stalled");

  // back-pressure on the queue only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !hd_ready |-> (out_valid && !out_ready))
    else $error("pipeline stalled without a waiting result");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the q32.32 atan2 stream: every input beat is run
// through a bit-exact angle predictor, and each result beat is compared
// against the oldest predicted angle across four flow-control phases.
// ----------------------------------------------------------------------------

// Holds predicted angles in beat order and checks result beats against them.
class angle_scoreboard;

  localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] PI_Q    = 64'h0000_0003_243F_6A88;
  localparam logic [63:0] HPI_Q   = 64'h0000_0001_921F_B544;
  localparam logic [63:0] QPI_Q   = 64'h0000_0000_C90F_DAA2;
  localparam logic [63:0] C0      = 64'h0000_0000_FFF7_37DA;
  localparam logic [63:0] C1      = 64'hFFFF_FFFF_AB71_7DF2;
  localparam logic [63:0] C2      = 64'h0000_0000_2E1D_B877;
  localparam logic [63:0] C3      = 64'hFFFF_FFFF_EA34_B946;
  localparam logic [63:0] C4      = 64'h0000_0000_0555_72F9;

  logic [34:0] angles_due[$];
  int          errors;
  int          beats_in;
  int          beats_out;

  function new();
    errors    = 0;
    beats_in  = 0;
    beats_out = 0;
  endfunction

  static function logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // signed q32.32 product, truncated toward zero, wrapped to 64 bits
  static function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] ua, ub, a0, a1, b0, b1, m;
    ua = mag64(a);
    ub = mag64(b);
    a0 = {32'd0, ua[31:0]};
    a1 = {32'd0, ua[63:32]};
    b0 = {32'd0, ub[31:0]};
    b1 = {32'd0, ub[63:32]};
    m  = ((a1 * b1) << 32) + a0 * b1 + a1 * b0 + ((a0 * b0) >> 32);
    return (a[63] ^ b[63]) ? (64'd0 - m) : m;
  endfunction

  // floor(a * 2^32 / b) for a <= b
  static function logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] r, q;
    r = a;
    q = 0;
    if (a >= b) return ONE_Q;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of z in [0, 1]
  static function logic [63:0] fx_atan01(logic [63:0] z);
    logic [63:0] base, z2, p, res;
    logic        folded;
    base   = 0;
    folded = 1'b0;
    if (z > HALF_Q) begin
      z      = fx_div(ONE_Q - z, z + ONE_Q);
      base   = QPI_Q;
      folded = 1'b1;
    end
    z2  = fx_mul(z, z);
    p   = fx_mul(C4, z2) + C3;
    p   = fx_mul(p, z2) + C2;
    p   = fx_mul(p, z2) + C1;
    p   = fx_mul(p, z2) + C0;
    res = base + fx_mul(z, p);
    if (folded) res = HPI_Q - res;
    return res;
  endfunction

  static function logic [34:0] predict_angle(logic [63:0] y, logic [63:0] x);
    logic [63:0] ay, ax, t, res;
    logic        swap;
    if (x == 0 && y == 0) return '0;
    ay   = mag64(y);
    ax   = mag64(x);
    swap = ay > ax;
    t    = fx_atan01(swap ? fx_div(ax, ay) : fx_div(ay, ax));
    res  = swap ? (HPI_Q - t) : t;
    if (x[63]) res = PI_Q - res;
    if (y[63]) res = 64'd0 - res;
    return res[34:0];
  endfunction

  function void note_input(logic [63:0] y, logic [63:0] x);
    angles_due.push_back(predict_angle(y, x));
    beats_in++;
  endfunction

  function void check_result(logic [34:0] angle);
    logic [34:0] want;
    beats_out++;
    if (angles_due.size() == 0) begin
      $error("unexpected result beat: angle %h", angle);
      errors++;
      return;
    end
    want = angles_due.pop_front();
    if (angle !== want) begin
      $error("angle mismatch: expected %h actual %h", want, angle);
      errors++;
    end
  endfunction

  function int pending();
    return angles_due.size();
  endfunction

endclass

module tb_top;

  localparam int  RANDOM_PER_PHASE = 240;
  localparam int  DRAIN_CYCLES     = 200;   // well past the pipeline latency
  localparam longint CYCLE_LIMIT   = 400000;
  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_VAL  = 64'h8000_0000_0000_0001;  // most negative allowed
  localparam logic [63:0] Q1       = 64'h0000_0001_0000_0000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [63:0] in_y_value;
  logic signed [63:0] in_x_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [34:0] out_angle;

  angle_scoreboard sb;
  longint cycles;
  int     in_idle_pct;    // chance per cycle that the sender sits idle
  int     out_stall_pct;  // chance per cycle that the receiver stalls

  fixed_point_atan2_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_y_value (in_y_value),
    .in_x_value (in_x_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_angle  (out_angle)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d angles outstanding", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // monitors: values read here are the pre-edge ones, i.e. what the DUT saw
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_y_value, in_x_value);
    if (rst_n && out_valid && out_ready) sb.check_result(out_angle);
  end

  // random 64-bit operand that never hits the excluded most negative value
  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v == 64'h8000_0000_0000_0000) v = MIN_VAL;
    return v;
  endfunction

  function automatic logic [63:0] rand_signed(logic [63:0] m);
    return $urandom_range(1) ? (64'd0 - m) : m;
  endfunction

  // one beat; valid stays up across back-to-back beats
  task automatic send_pair(logic [63:0] y, logic [63:0] x);
    in_valid   <= 1'b1;
    in_y_value <= y;
    in_x_value <= x;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // random pair biased toward the interesting regions
  task automatic send_random();
    logic [63:0] a, b;
    case ($urandom_range(7))
      0, 1: begin                       // full-width noise
        a = rand_word();
        b = rand_word();
      end
      2: begin                          // small magnitudes, from zero up to just under one unit
        a = rand_signed({32'd0, $urandom} >> $urandom_range(31));
        b = rand_signed({32'd0, $urandom} >> $urandom_range(31));
      end
      3: begin                          // equal magnitudes, any signs
        a = rand_word() >> $urandom_range(1, 40);
        b = rand_signed(a);
        a = rand_signed(a);
      end
      4: begin                          // ratio near one half: fold boundary
        b = (rand_word() >> $urandom_range(2, 30)) | 64'd4;
        a = (b >> 1) + $urandom_range(4) - 2;
        a = rand_signed(a);
        b = rand_signed(b);
      end
      5: begin                          // one coordinate on an axis
        a = rand_word();
        b = 0;
        if ($urandom_range(1)) {a, b} = {b, a};
      end
      default: begin                    // moderate q32.32 values
        a = rand_signed({16'd0, $urandom, 16'(($urandom))} >> $urandom_range(16));
        b = rand_signed({16'd0, $urandom, 16'(($urandom))} >> $urandom_range(16));
      end
    endcase
    send_pair(a, b);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n) send_random();
  endtask

  initial begin
    in_valid      = 1'b0;
    in_y_value    = '0;
    in_x_value    = '0;
    out_ready     = 1'b0;
    cycles        = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    sb            = new();
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero point, axes, equal magnitudes, extremes, fold boundary
    send_pair(0, 0);
    send_pair(0, Q1);
    send_pair(0, -Q1);
    send_pair(Q1, 0);
    send_pair(-Q1, 0);
    send_pair(Q1, Q1);
    send_pair(Q1, -Q1);
    send_pair(-Q1, Q1);
    send_pair(-Q1, -Q1);
    send_pair(MAX_POS, MAX_POS);
    send_pair(MIN_VAL, MIN_VAL);
    send_pair(MAX_POS, MIN_VAL);
    send_pair(MIN_VAL, MAX_POS);
    send_pair(MAX_POS, 1);
    send_pair(1, MAX_POS);
    send_pair(MIN_VAL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, MIN_VAL);
    send_pair(1, 1);
    send_pair(Q1 >> 1, Q1);             // ratio exactly one half
    send_pair((Q1 >> 1) + 1, Q1);       // just over one half
    send_pair(-((Q1 >> 1) + 1), -Q1);
    send_pair(MAX_POS, 0);
    send_pair(0, MIN_VAL);

    // random part across the flow-control phases
    run_phase(0, 0, RANDOM_PER_PHASE);
    run_phase(87, 0, RANDOM_PER_PHASE);
    run_phase(0, 87, RANDOM_PER_PHASE);
    run_phase(9, 9, RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats and %0d result beats over four flow-control phases",
             sb.beats_in, sb.beats_out);
    $display("directed axes, extremes and fold boundary, then random operands");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
